// ===== rtl/conv3b_pkg.sv =====
package conv3b_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH      = 256;
  localparam int MAX_HEIGHT     = 256;
  localparam int COEF_FRAC_BITS = 8;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  // Fixed field widths
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 8;
  localparam int DIM_W     = 9;
  localparam int MODE_W    = 2;
  localparam int COEF_W    = 16;
  localparam int TAPS      = 3;
  localparam int KERN_W    = COEF_W * TAPS;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = KERN_W;

  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(TAPS * TAPS);

  localparam logic [DIM_W-1:0]  DIM_RESET      = DIM_W'(256);
  localparam logic [KERN_W-1:0] KERN_MID_RESET = KERN_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BORDER_MODE   = 3'd0,
    CFG_IMAGE_WIDTH   = 3'd1,
    CFG_IMAGE_HEIGHT  = 3'd2,
    CFG_KERNEL_TOP    = 3'd3,
    CFG_KERNEL_MIDDLE = 3'd4,
    CFG_KERNEL_BOTTOM = 3'd5
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 2'd0,
    MODE_REFLECT  = 2'd1,
    MODE_CIRCULAR = 2'd2
  } border_mode_e;

  typedef enum logic {
    ACT_WRITE   = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_e;

  // Kernel tap position along one axis; TAP_NEXT pairs with offset +1
  typedef logic [1:0] tap_t;
  localparam tap_t TAP_NEXT   = 2'd0;
  localparam tap_t TAP_CENTRE = 2'd1;
  localparam tap_t TAP_PREV   = 2'd2;

  typedef struct packed {
    logic load_wr;
    logic load_cmp;
    logic issue;
    logic first;
    logic last;
    tap_t tap_row;
    tap_t tap_col;
  } cmd_t;

endpackage

// ===== rtl/conv3b_ram.sv =====
module conv3b_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/conv3b_ctrl.sv =====
module conv3b_ctrl
  import conv3b_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic action_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  tap_t   tap_r_q;
  tap_t   tap_c_q;
  logic   busy_q;

  logic accept;
  logic load_cmp;
  logic tap_last;

  assign accept   = start_i && !busy_q;
  assign load_cmp = accept && (action_i == ACT_COMPUTE);
  assign tap_last = (tap_r_q == TAP_PREV) && (tap_c_q == TAP_PREV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_r_q <= TAP_NEXT;
      tap_c_q <= TAP_NEXT;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (load_cmp) begin
            state_q <= ST_RUN;
            tap_r_q <= TAP_NEXT;
            tap_c_q <= TAP_NEXT;
            busy_q  <= 1'b1;
          end
        end
        ST_RUN: begin
          if (tap_last) begin
            // a new compute may follow straight on from the last read
            if (load_cmp) begin
              tap_r_q <= TAP_NEXT;
              tap_c_q <= TAP_NEXT;
              busy_q  <= 1'b1;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            if (tap_c_q == TAP_PREV) begin
              tap_c_q <= TAP_NEXT;
              tap_r_q <= tap_r_q + 2'd1;
            end else begin
              tap_c_q <= tap_c_q + 2'd1;
            end
            // release the input side during the final read
            if ((tap_r_q == TAP_PREV) && (tap_c_q == TAP_CENTRE)) begin
              busy_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o         = busy_q;
  assign cmd_o.load_wr  = accept && (action_i == ACT_WRITE);
  assign cmd_o.load_cmp = load_cmp;
  assign cmd_o.issue    = (state_q == ST_RUN);
  assign cmd_o.first    = (tap_r_q == TAP_NEXT) && (tap_c_q == TAP_NEXT);
  assign cmd_o.last     = tap_last;
  assign cmd_o.tap_row  = tap_r_q;
  assign cmd_o.tap_col  = tap_c_q;

endmodule

// ===== rtl/conv3b_dp.sv =====
module conv3b_dp
  import conv3b_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [PIX_W-1:0]     pixel_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 out_valid_o,
  output logic [PIX_W-1:0]     out_pixel_o
);

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic zero;
  } tag_t;

  // Configuration registers
  logic [MODE_W-1:0] mode_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [KERN_W-1:0] kern_q [TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_REFLECT;
      width_q   <= DIM_RESET;
      height_q  <= DIM_RESET;
      kern_q[0] <= '0;
      kern_q[1] <= KERN_MID_RESET;
      kern_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BORDER_MODE:   mode_q    <= cfg_wdata_i[MODE_W-1:0];
        CFG_IMAGE_WIDTH:   width_q   <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_KERNEL_TOP:    kern_q[0] <= cfg_wdata_i[KERN_W-1:0];
        CFG_KERNEL_MIDDLE: kern_q[1] <= cfg_wdata_i[KERN_W-1:0];
        CFG_KERNEL_BOTTOM: kern_q[2] <= cfg_wdata_i[KERN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, clamp to the store
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic             border_on;
  logic             circ;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign circ      = (mode_q == MODE_CIRCULAR);
  assign border_on = (mode_q == MODE_REFLECT) || circ;

  // Pixel write path: the store is written in the cycle after the transfer
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [PIX_W-1:0]  wr_pix_q;
  logic              wr_in_range;

  assign wr_in_range = (32'(row_i) < MAX_HEIGHT) && (32'(col_i) < MAX_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.load_wr && wr_in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      wr_addr_q <= ADDR_W'(32'(row_i) * MAX_WIDTH + 32'(col_i));
      wr_pix_q  <= pixel_i;
    end
  end

  // Compute request capture
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic               zero_q;
  logic               zero_d;
  logic [DIM_W-1:0]   row_x;
  logic [DIM_W-1:0]   col_x;

  assign row_x = DIM_W'(row_i);
  assign col_x = DIM_W'(col_i);

  always_comb begin
    zero_d = (row_x >= h_eff) || (col_x >= w_eff);
    if (!border_on) begin
      if ((row_x == '0) || (col_x == '0) ||
          (row_x + DIM_W'(1) >= h_eff) || (col_x + DIM_W'(1) >= w_eff)) begin
        zero_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cmp) begin
      row_q  <= row_i;
      col_q  <= col_i;
      zero_q <= zero_d;
    end
  end

  // Neighbour index along one axis, with border resolution
  function automatic logic [DIM_W-1:0] nbr_idx(input logic [DIM_W-1:0] ctr,
                                               input tap_t             tap,
                                               input logic [DIM_W-1:0] size,
                                               input logic             wrap_on,
                                               input logic             wrap_circ);
    logic [DIM_W-1:0] nxt;
    logic [DIM_W-1:0] res;
    nxt = ctr + DIM_W'(1);
    case (tap)
      TAP_NEXT: begin
        if (wrap_on && (nxt >= size)) begin
          res = wrap_circ ? '0 : size - DIM_W'(1);
        end else begin
          res = nxt;
        end
      end
      TAP_PREV: begin
        if (wrap_on && (ctr == '0)) begin
          res = wrap_circ ? size - DIM_W'(1) : '0;
        end else begin
          res = ctr - DIM_W'(1);
        end
      end
      default: res = ctr;
    endcase
    return res;
  endfunction

  logic [DIM_W-1:0]  nbr_row;
  logic [DIM_W-1:0]  nbr_col;
  logic [ADDR_W-1:0] tap_addr;

  assign nbr_row  = nbr_idx(DIM_W'(row_q), cmd_i.tap_row, h_eff, border_on, circ);
  assign nbr_col  = nbr_idx(DIM_W'(col_q), cmd_i.tap_col, w_eff, border_on, circ);
  assign tap_addr = ADDR_W'(32'(nbr_row) * MAX_WIDTH + 32'(nbr_col));

  // Frame store
  logic              ram_en;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;

  assign ram_en   = wr_pend_q || cmd_i.issue;
  assign ram_addr = wr_pend_q ? wr_addr_q : tap_addr;

  conv3b_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (wr_pend_q),
    .addr_i  (ram_addr),
    .wdata_i (wr_pix_q),
    .rdata_o (ram_rdata)
  );

  // Stage 1: read data back, pick the coefficient
  tag_t s1_q;
  tap_t s1_tr_q;
  tap_t s1_tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q.valid <= cmd_i.issue;
      s1_q.first <= cmd_i.first;
      s1_q.last  <= cmd_i.last;
      s1_q.zero  <= zero_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tr_q <= cmd_i.tap_row;
    s1_tc_q <= cmd_i.tap_col;
  end

  logic [KERN_W-1:0]        kern_row;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod_d;

  assign kern_row = kern_q[s1_tr_q];

  always_comb begin
    case (s1_tc_q)
      TAP_NEXT:   coef = kern_row[COEF_W-1:0];
      TAP_CENTRE: coef = kern_row[2*COEF_W-1:COEF_W];
      default:    coef = kern_row[3*COEF_W-1:2*COEF_W];
    endcase
  end

  assign prod_d = coef * $signed({1'b0, ram_rdata});

  // Stage 2: product register
  tag_t                     s2_q;
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Accumulate, then truncate and saturate on the last tap
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] quo;
  logic [PIX_W-1:0]        sat_pix;

  assign acc_base = s2_q.first ? '0 : acc_q;
  assign sum      = acc_base + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign quo      = sum >>> COEF_FRAC_BITS;

  always_comb begin
    if (sum[ACC_W-1] || (sum == '0)) begin
      sat_pix = '0;
    end else if (quo > ACC_W'(255)) begin
      sat_pix = '1;
    end else begin
      sat_pix = quo[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q.valid) begin
      acc_q <= sum;
    end
  end

  logic             out_valid_q;
  logic [PIX_W-1:0] out_pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s2_q.valid && s2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q.valid && s2_q.last) begin
      out_pixel_q <= s2_q.zero ? '0 : sat_pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;

endmodule

// ===== rtl/conv3x3_border_modes.sv =====
// Channel    Direction  Transfer when            Signals
// request    in         start && !busy           action_i row_i col_i pixel_i
// result     out        out_valid_o (one cycle)  out_pixel_o
// config     in         cfg_we_i                 cfg_index_i cfg_wdata_i
//
// For a pixel write, the store is written the cycle after the transfer.
// A compute runs nine neighbour reads through the single port of the frame store,
// one per cycle; busy is high for all reads but the last and low during the last
// read, so a new request is taken at its end and the next compute follows straight on.
// After the last read, the result passes the stage 1, stage 2 and output registers.
// Reset sets control and configuration to defaults; the frame store holds no reset value.
// The result receiver cannot stall: each result is shown for one cycle only.
module conv3x3_border_modes
  import conv3b_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 action_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 out_valid_o,
  output logic [PIX_W-1:0]     out_pixel_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cmd_t cmd;

  conv3b_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  conv3b_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .row_i       (row_i),
    .col_i       (col_i),
    .pixel_i     (pixel_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_pixel_o (out_pixel_o)
  );

  // Result strobes are never back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("back-to-back result strobes");

  // A compute transfer starts the read sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i) |=> (busy && cmd.issue && cmd.first))
    else $error("compute transfer did not start the read sequence");

  // A pixel write never occupies the request side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !action_i) |=> !busy)
    else $error("pixel write raised busy");

  // Every last neighbour read is followed by a result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.issue && cmd.last) |-> ##3 out_valid_o)
    else $error("result missing after the last read");

endmodule
